// ===== design/char_lcd_nibble_sequencer_assert.svh =====
// Assertion macros used by the top level of the character display sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCDNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdns same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCDNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdns next-cycle check failed");

`endif

// ===== design/lcdns_pkg.sv =====
// Types, codes and the microcode program of the character display sequencer.
package lcdns_pkg;

  localparam int CMD_W     = 3;
  localparam int HOLD_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W      = 5;
  localparam int LINE_CHARS_DEFAULT = 16;

  // Request codes.
  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DATA   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 2'd1;

  localparam logic [HOLD_W-1:0] SHORT_HOLD_RESET = 16'd10;
  localparam logic [HOLD_W-1:0] LONG_HOLD_RESET  = 16'd25000;

  // DDRAM address bases of the two display lines.
  localparam logic [7:0] ADDR_LINE0 = 8'h80;
  localparam logic [7:0] ADDR_LINE1 = 8'hC0;

  // Nibble source codes.
  localparam logic [1:0] NIB_HI = 2'd0;
  localparam logic [1:0] NIB_LO = 2'd1;
  localparam logic [1:0] NIB_K  = 2'd2;

  // Program entry points.
  localparam logic [PC_W-1:0] PC_INIT   = 5'd0;
  localparam logic [PC_W-1:0] PC_CLEAR  = 5'd13;
  localparam logic [PC_W-1:0] PC_BYTE   = 5'd18;
  localparam logic [PC_W-1:0] PC_DATA   = 5'd22;
  localparam logic [PC_W-1:0] PC_CURSOR = 5'd26;

  typedef struct packed {
    logic            emit;
    logic            enable;
    logic            rs;
    logic [1:0]      nib_sel;
    logic [3:0]      nib_k;
    logic            hold_long;
    logic            last;
    logic            load_addr;
    logic            jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   active;
    ucode_t word;
  } step_t;

  function automatic ucode_t mk_seg(logic en, logic rs, logic [1:0] sel, logic [3:0] k,
                                    logic hold_long, logic last);
    ucode_t w;
    w           = '0;
    w.emit      = 1'b1;
    w.enable    = en;
    w.rs        = rs;
    w.nib_sel   = sel;
    w.nib_k     = k;
    w.hold_long = hold_long;
    w.last      = last;
    return w;
  endfunction

  // The microcode ROM. Init falls through into the clear program.
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      5'd0:  w = mk_seg(1'b0, 1'b0, NIB_K, 4'h0, 1'b1, 1'b0);
      5'd1:  w = mk_seg(1'b1, 1'b0, NIB_K, 4'h3, 1'b0, 1'b0);
      5'd2:  w = mk_seg(1'b0, 1'b0, NIB_K, 4'h3, 1'b1, 1'b0);
      5'd3:  w = mk_seg(1'b1, 1'b0, NIB_K, 4'h3, 1'b0, 1'b0);
      5'd4:  w = mk_seg(1'b0, 1'b0, NIB_K, 4'h3, 1'b1, 1'b0);
      5'd5:  w = mk_seg(1'b1, 1'b0, NIB_K, 4'h3, 1'b0, 1'b0);
      5'd6:  w = mk_seg(1'b0, 1'b0, NIB_K, 4'h3, 1'b1, 1'b0);
      5'd7:  w = mk_seg(1'b1, 1'b0, NIB_K, 4'h2, 1'b0, 1'b0);
      5'd8:  w = mk_seg(1'b0, 1'b0, NIB_K, 4'h2, 1'b1, 1'b0);
      5'd9:  w = mk_seg(1'b1, 1'b0, NIB_K, 4'h0, 1'b1, 1'b0);
      5'd10: w = mk_seg(1'b0, 1'b0, NIB_K, 4'h0, 1'b1, 1'b0);
      5'd11: w = mk_seg(1'b1, 1'b0, NIB_K, 4'hF, 1'b0, 1'b0);
      5'd12: w = mk_seg(1'b0, 1'b0, NIB_K, 4'hF, 1'b1, 1'b0);
      5'd13: w = mk_seg(1'b1, 1'b0, NIB_K, 4'h0, 1'b1, 1'b0);
      5'd14: w = mk_seg(1'b0, 1'b0, NIB_K, 4'h0, 1'b1, 1'b0);
      5'd15: w = mk_seg(1'b1, 1'b0, NIB_K, 4'h1, 1'b0, 1'b0);
      5'd16: w = mk_seg(1'b0, 1'b0, NIB_K, 4'h1, 1'b1, 1'b0);
      5'd17: w = mk_seg(1'b0, 1'b0, NIB_K, 4'h1, 1'b0, 1'b1);
      5'd18: w = mk_seg(1'b1, 1'b0, NIB_HI, 4'h0, 1'b1, 1'b0);
      5'd19: w = mk_seg(1'b0, 1'b0, NIB_HI, 4'h0, 1'b1, 1'b0);
      5'd20: w = mk_seg(1'b1, 1'b0, NIB_LO, 4'h0, 1'b0, 1'b0);
      5'd21: w = mk_seg(1'b0, 1'b0, NIB_LO, 4'h0, 1'b1, 1'b1);
      5'd22: w = mk_seg(1'b1, 1'b1, NIB_HI, 4'h0, 1'b0, 1'b0);
      5'd23: w = mk_seg(1'b0, 1'b1, NIB_HI, 4'h0, 1'b1, 1'b0);
      5'd24: w = mk_seg(1'b1, 1'b1, NIB_LO, 4'h0, 1'b0, 1'b0);
      5'd25: w = mk_seg(1'b0, 1'b1, NIB_LO, 4'h0, 1'b1, 1'b1);
      5'd26: begin
        w.load_addr = 1'b1;
        w.jump      = 1'b1;
        w.target    = PC_BYTE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== design/char_lcd_nibble_sequencer.sv =====
// Top level of the 4-bit character display nibble sequencer.
//
// A request (init, command byte, data byte, set cursor, clear) is taken at a
// rising edge where start is high and busy is low. It expands into a run of
// pin-state segments, each shown for one cycle on the out_ ports and marked
// by out_valid; the last segment of a request carries out_last.
// The request edge loads the step counter; each emitting program step then
// loads its segment into the output register, from which it is shown. Set
// cursor first spends one step loading the address, which emits no segment.
// busy stays high while the step counter walks through the microcode
// program: 4 steps for a command or data byte, 5 for set cursor and clear,
// 18 for init. Segments follow one per cycle. busy drops as the last segment
// is shown, so the next request can be taken at the edge that ends that cycle.
// Requests with an unknown code are taken, produce no segments and leave busy
// low, so the next request can be taken at the following edge.
// The hold registers are written on the cfg_ port: index 0 is the short hold,
// index 1 the long hold; other indexes are ignored.
// Reset returns the holds to 10 and 25000 units and stops any running program.
// The receiver cannot stall: every segment is taken in the cycle it is shown.
`include "char_lcd_nibble_sequencer_assert.svh"

module char_lcd_nibble_sequencer #(
  parameter int LINE_CHARS = lcdns_pkg::LINE_CHARS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [lcdns_pkg::CMD_W-1:0]      in_cmd,
  input  logic [7:0]                       in_byte_value,
  input  logic                             in_row,
  input  logic [7:0]                       in_column,
  output logic                             out_valid,
  output logic                             out_reg_select,
  output logic                             out_enable_pin,
  output logic [3:0]                       out_nibble,
  output logic [lcdns_pkg::HOLD_W-1:0]     out_hold_units,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdns_pkg::HOLD_W-1:0]     cfg_data
);

  // A request is taken only while no program is running.
  logic             accept;
  lcdns_pkg::step_t step;

  assign accept = start && !busy;

  // The sequencer owns the step counter and fetches one control word per step.
  lcdns_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cmd    (in_cmd),
    .busy   (busy),
    .step   (step)
  );

  // The datapath turns each control word into a registered pin segment.
  lcdns_datapath #(
    .LINE_CHARS (LINE_CHARS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte_value  (in_byte_value),
    .in_row         (in_row),
    .in_column      (in_column),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .step           (step),
    .out_valid      (out_valid),
    .out_reg_select (out_reg_select),
    .out_enable_pin (out_enable_pin),
    .out_nibble     (out_nibble),
    .out_hold_units (out_hold_units),
    .out_last       (out_last)
  );

  // A known request starts a program; an unknown one leaves the block idle.
  `LCDNS_ASSERT_NEXT(a_known_starts, clk, rst_n, accept && in_cmd <= lcdns_pkg::CMD_CLEAR, busy)
  `LCDNS_ASSERT_NEXT(a_unknown_idle, clk, rst_n, accept && in_cmd > lcdns_pkg::CMD_CLEAR, !busy)
  // Every segment comes from a step that ran in the previous cycle.
  `LCDNS_ASSERT_SAME(a_seg_from_step, clk, rst_n, out_valid, $past(busy))
  // The closing segment ends the program and always leaves E low.
  `LCDNS_ASSERT_SAME(a_last_ends, clk, rst_n, out_valid && out_last, !busy && !out_enable_pin)

endmodule

// ===== design/lcdns_sequencer.sv =====
// Step counter, dispatch and microcode fetch of the display sequencer.
module lcdns_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [lcdns_pkg::CMD_W-1:0] cmd,
  output logic                        busy,
  output lcdns_pkg::step_t            step
);

  logic                         busy_r, busy_nxt;
  logic [lcdns_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [lcdns_pkg::PC_W-1:0]   entry;
  logic                         entry_ok;
  lcdns_pkg::ucode_t            word;

  always_comb begin
    entry_ok = 1'b1;
    entry    = lcdns_pkg::PC_INIT;
    unique case (cmd)
      lcdns_pkg::CMD_INIT:   entry = lcdns_pkg::PC_INIT;
      lcdns_pkg::CMD_BYTE:   entry = lcdns_pkg::PC_BYTE;
      lcdns_pkg::CMD_DATA:   entry = lcdns_pkg::PC_DATA;
      lcdns_pkg::CMD_CURSOR: entry = lcdns_pkg::PC_CURSOR;
      lcdns_pkg::CMD_CLEAR:  entry = lcdns_pkg::PC_CLEAR;
      default:               entry_ok = 1'b0;
    endcase
  end

  assign word = lcdns_pkg::ucode_rom(pc_r);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (busy_r) begin
      if (word.last) begin
        busy_nxt = 1'b0;
      end else if (word.jump) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end else if (accept && entry_ok) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= lcdns_pkg::PC_INIT;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy        = busy_r;
  assign step.active = busy_r;
  assign step.word   = word;

endmodule

// ===== design/lcdns_datapath.sv =====
// Request byte, cursor address, hold registers and segment output register.
module lcdns_datapath #(
  parameter int LINE_CHARS = lcdns_pkg::LINE_CHARS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [7:0]                       in_byte_value,
  input  logic                             in_row,
  input  logic [7:0]                       in_column,
  input  logic                             cfg_we,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdns_pkg::HOLD_W-1:0]     cfg_data,
  input  lcdns_pkg::step_t                 step,
  output logic                             out_valid,
  output logic                             out_reg_select,
  output logic                             out_enable_pin,
  output logic [3:0]                       out_nibble,
  output logic [lcdns_pkg::HOLD_W-1:0]     out_hold_units,
  output logic                             out_last
);

  // Column modulo LINE_CHARS by a reciprocal: floor(col * RECIP / 2^16) is the
  // exact quotient for any 8-bit column and line lengths up to 64.
  localparam int RECIP   = (65536 + LINE_CHARS - 1) / LINE_CHARS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = 8 + RECIP_W;
  localparam int REM_W   = $clog2(LINE_CHARS);

  logic [lcdns_pkg::HOLD_W-1:0] short_hold_r, long_hold_r;
  logic [7:0]                   byte_r;
  logic                         row_r;
  logic [7:0]                   col_r;
  logic [PROD_W-1:0]            prod_r;
  logic [PROD_W-17:0]           quot;
  logic [15:0]                  qmul;
  logic [15:0]                  rem_full;
  logic [7:0]                   addr;
  logic [3:0]                   nib;
  logic                         out_valid_r;
  logic                         rs_r, en_r, last_r;
  logic [3:0]                   nib_r;
  logic [lcdns_pkg::HOLD_W-1:0] hold_r;

  assign quot     = prod_r[PROD_W-1:16];
  assign qmul     = 16'(quot) * 16'(LINE_CHARS);
  assign rem_full = 16'(col_r) - qmul;
  assign addr     = (row_r ? lcdns_pkg::ADDR_LINE1 : lcdns_pkg::ADDR_LINE0)
                    + 8'(rem_full[REM_W-1:0]);

  always_comb begin
    unique case (step.word.nib_sel)
      lcdns_pkg::NIB_HI: nib = byte_r[7:4];
      lcdns_pkg::NIB_LO: nib = byte_r[3:0];
      lcdns_pkg::NIB_K:  nib = step.word.nib_k;
      default:           nib = step.word.nib_k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_hold_r <= lcdns_pkg::SHORT_HOLD_RESET;
      long_hold_r  <= lcdns_pkg::LONG_HOLD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lcdns_pkg::CFG_SHORT_HOLD) begin
        short_hold_r <= cfg_data;
      end else if (cfg_index == lcdns_pkg::CFG_LONG_HOLD) begin
        long_hold_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte_value;
      row_r  <= in_row;
      col_r  <= in_column;
      prod_r <= PROD_W'(in_column) * PROD_W'(RECIP);
    end else if (step.active && step.word.load_addr) begin
      byte_r <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= step.active && step.word.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step.active && step.word.emit) begin
      rs_r   <= step.word.rs;
      en_r   <= step.word.enable;
      nib_r  <= nib;
      hold_r <= step.word.hold_long ? long_hold_r : short_hold_r;
      last_r <= step.word.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = rs_r;
  assign out_enable_pin = en_r;
  assign out_nibble     = nib_r;
  assign out_hold_units = hold_r;
  assign out_last       = last_r;

endmodule

// ===== verif/char_lcd_nibble_sequencer_tb.sv =====
// Self-checking testbench for the 4-bit character display nibble sequencer.
module char_lcd_nibble_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CHARS = 16;
  // Cycles allowed after the last expected segment for the block to finish
  // an unknown request or its trailing bookkeeping.
  localparam int SETTLE_CYCLES = 8;
  // Upper bound on cycles spent waiting for outstanding segments to drain.
  localparam int DRAIN_LIMIT = 4000;

  // One pin-state segment as seen on the out_ ports.
  typedef struct packed {
    logic                         rs;
    logic                         en;
    logic [3:0]                   nib;
    logic [lcdns_pkg::HOLD_W-1:0] hold;
    logic                         last;
  } pin_segment_t;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [lcdns_pkg::CMD_W-1:0]     in_cmd;
  logic [7:0]                      in_byte_value;
  logic                            in_row;
  logic [7:0]                      in_column;
  logic                            out_valid;
  logic                            out_reg_select;
  logic                            out_enable_pin;
  logic [3:0]                      out_nibble;
  logic [lcdns_pkg::HOLD_W-1:0]    out_hold_units;
  logic                            out_last;
  logic                            cfg_we;
  logic [lcdns_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lcdns_pkg::HOLD_W-1:0]    cfg_data;

  // The testbench's own copy of the two hold registers.
  logic [lcdns_pkg::HOLD_W-1:0] model_short_hold;
  logic [lcdns_pkg::HOLD_W-1:0] model_long_hold;

  // Segments predicted for accepted requests, oldest first.
  pin_segment_t pending_segments[$];

  int idle_percent;
  int mismatch_count;
  int segments_compared;
  int requests_by_code[8];

  char_lcd_nibble_sequencer #(
    .LINE_CHARS(LINE_CHARS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .out_valid     (out_valid),
    .out_reg_select(out_reg_select),
    .out_enable_pin(out_enable_pin),
    .out_nibble    (out_nibble),
    .out_hold_units(out_hold_units),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Every failure goes through here: one line, one count.
  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Segment predictor. Each accepted request is expanded into the run of
  // pin states the display should see, using the holds that were current
  // when the request was taken.
  // ---------------------------------------------------------------------
  function automatic void queue_segment(logic rs, logic en, logic [3:0] nib,
                                        logic [lcdns_pkg::HOLD_W-1:0] hold);
    pin_segment_t seg;
    seg.rs   = rs;
    seg.en   = en;
    seg.nib  = nib;
    seg.hold = hold;
    seg.last = 1'b0;
    pending_segments.push_back(seg);
  endfunction

  // A nibble is an E-high pulse followed by an E-low settle on the long hold.
  function automatic void queue_nibble(logic rs, logic [3:0] nib,
                                       logic [lcdns_pkg::HOLD_W-1:0] pulse);
    queue_segment(rs, 1'b1, nib, pulse);
    queue_segment(rs, 1'b0, nib, model_long_hold);
  endfunction

  // Command bytes open with a long pulse; the low nibble pulse is short.
  function automatic void queue_command_byte(logic [7:0] b);
    queue_nibble(1'b0, b[7:4], model_long_hold);
    queue_nibble(1'b0, b[3:0], model_short_hold);
  endfunction

  // Clear is command 0x01 plus one short wait that keeps the last nibble.
  function automatic void queue_clear();
    queue_command_byte(8'h01);
    queue_segment(1'b0, 1'b0, 4'h1, model_short_hold);
  endfunction

  function automatic void predict_request(logic [lcdns_pkg::CMD_W-1:0] cmd, logic [7:0] b,
                                          logic row, logic [7:0] col);
    int        first_new;
    logic [7:0] addr;
    first_new = pending_segments.size();
    case (cmd)
      lcdns_pkg::CMD_INIT: begin
        // Power-up wait shows all pins low, then the wake-up nibbles.
        queue_segment(1'b0, 1'b0, 4'h0, model_long_hold);
        queue_nibble(1'b0, 4'h3, model_short_hold);
        queue_nibble(1'b0, 4'h3, model_short_hold);
        queue_nibble(1'b0, 4'h3, model_short_hold);
        queue_nibble(1'b0, 4'h2, model_short_hold);
        queue_command_byte(8'h0F);
        queue_clear();
      end
      lcdns_pkg::CMD_BYTE: begin
        queue_command_byte(b);
      end
      lcdns_pkg::CMD_DATA: begin
        queue_nibble(1'b1, b[7:4], model_short_hold);
        queue_nibble(1'b1, b[3:0], model_short_hold);
      end
      lcdns_pkg::CMD_CURSOR: begin
        addr = (row ? lcdns_pkg::ADDR_LINE1 : lcdns_pkg::ADDR_LINE0)
               + 8'(col % LINE_CHARS);
        queue_command_byte(addr);
      end
      lcdns_pkg::CMD_CLEAR: begin
        queue_clear();
      end
      default: begin
        // Unknown request codes are swallowed without any pin activity.
      end
    endcase
    if (pending_segments.size() > first_new)
      pending_segments[pending_segments.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker. The receiver cannot stall, so every strobed segment is
  // compared with the oldest prediction at the edge that ends its cycle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_segments
    pin_segment_t seen;
    pin_segment_t wanted;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      seen.rs   = out_reg_select;
      seen.en   = out_enable_pin;
      seen.nib  = out_nibble;
      seen.hold = out_hold_units;
      seen.last = out_last;
      if (pending_segments.size() == 0) begin
        report_mismatch($sformatf("segment with nothing pending: rs=%b e=%b nib=%h hold=%0d last=%b",
                                  seen.rs, seen.en, seen.nib, seen.hold, seen.last));
      end else begin
        wanted = pending_segments.pop_front();
        segments_compared++;
        if (out_valid !== 1'b1 || seen !== wanted)
          report_mismatch($sformatf({"segment got rs=%b e=%b nib=%h hold=%0d last=%b, ",
                                     "wanted rs=%b e=%b nib=%h hold=%0d last=%b"},
                                    seen.rs, seen.en, seen.nib, seen.hold, seen.last,
                                    wanted.rs, wanted.en, wanted.nib, wanted.hold,
                                    wanted.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request driver. Inputs change on the falling edge; a request counts as
  // taken at the first rising edge where start is high and busy is low.
  // Before each request the sender sits idle with start low for a random
  // number of cycles, each cycle idle with the chance set by idle_percent,
  // so new requests arrive at varied steps of the previous program.
  // ---------------------------------------------------------------------
  task automatic send_request(logic [lcdns_pkg::CMD_W-1:0] cmd, logic [7:0] b, logic row,
                              logic [7:0] col);
    while (idle_percent > 0 && $urandom_range(1, 100) <= idle_percent) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_byte_value <= b;
    in_row        <= row;
    in_column     <= col;
    @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
    predict_request(cmd, b, row, col);
    requests_by_code[cmd]++;
  endtask

  // Lower start, let every predicted segment arrive, then give the block a
  // few spare cycles in case the last request produced no segments.
  task automatic drain_requests();
    int waited;
    @(negedge clk);
    start  <= 1'b0;
    waited = 0;
    while (pending_segments.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_segments.size() > 0) begin
      report_mismatch($sformatf("%0d predicted segments never appeared",
                                pending_segments.size()));
      pending_segments.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle. Unknown indexes leave the model alone.
  task automatic write_register(logic [lcdns_pkg::CFG_IDX_W-1:0] idx,
                                logic [lcdns_pkg::HOLD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == lcdns_pkg::CFG_SHORT_HOLD)
      model_short_hold = value;
    else if (idx == lcdns_pkg::CFG_LONG_HOLD)
      model_long_hold = value;
  endtask

  // Extremes show up often so both ends of the hold range get exercised.
  function automatic logic [lcdns_pkg::HOLD_W-1:0] pick_hold();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return lcdns_pkg::HOLD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // The hold registers must come out of reset at their documented values.
  task automatic test_reset_holds();
    idle_percent = 0;
    send_request(lcdns_pkg::CMD_BYTE, 8'h3C, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_DATA, 8'hC3, 1'b1, 8'hFF);
    drain_requests();
  endtask

  // Every request type, the field extremes and the odd cases, back to back.
  task automatic test_directed_requests();
    idle_percent = 0;
    send_request(lcdns_pkg::CMD_INIT,   8'h00, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_BYTE,   8'h00, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_BYTE,   8'hFF, 1'b1, 8'hFF);
    send_request(lcdns_pkg::CMD_DATA,   8'h00, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_DATA,   8'hFF, 1'b1, 8'hFF);
    send_request(lcdns_pkg::CMD_DATA,   8'hA5, 1'b0, 8'h5A);
    // Cursor on both lines, at the column edges and with wrap-around.
    send_request(lcdns_pkg::CMD_CURSOR, 8'hFF, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_CURSOR, 8'h00, 1'b1, 8'h0F);
    send_request(lcdns_pkg::CMD_CURSOR, 8'h00, 1'b0, 8'h10);
    send_request(lcdns_pkg::CMD_CURSOR, 8'hFF, 1'b1, 8'hFF);
    send_request(lcdns_pkg::CMD_CURSOR, 8'h5A, 1'b0, 8'hAA);
    send_request(lcdns_pkg::CMD_CLEAR,  8'hFF, 1'b1, 8'hFF);
    // Unknown codes must be taken quietly, even wedged between real ones.
    send_request(3'd5,                  8'hFF, 1'b1, 8'hFF);
    send_request(lcdns_pkg::CMD_BYTE,   8'h81, 1'b1, 8'h77);
    send_request(3'd6,                  8'h00, 1'b0, 8'h00);
    send_request(3'd7,                  8'hAA, 1'b1, 8'h55);
    send_request(lcdns_pkg::CMD_DATA,   8'h7E, 1'b0, 8'hC3);
    send_request(lcdns_pkg::CMD_CLEAR,  8'h00, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_INIT,   8'hFF, 1'b1, 8'hFF);
    drain_requests();
  endtask

  // Both holds at zero, both at full scale, then writes to the unused
  // indexes, which must not disturb either hold.
  task automatic test_hold_extremes();
    idle_percent = 0;
    write_register(lcdns_pkg::CFG_SHORT_HOLD, '0);
    write_register(lcdns_pkg::CFG_LONG_HOLD, '0);
    send_request(lcdns_pkg::CMD_INIT, 8'h00, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_DATA, 8'h96, 1'b0, 8'h00);
    drain_requests();
    write_register(lcdns_pkg::CFG_SHORT_HOLD, '1);
    write_register(lcdns_pkg::CFG_LONG_HOLD, '1);
    send_request(lcdns_pkg::CMD_BYTE, 8'h69, 1'b0, 8'h00);
    send_request(lcdns_pkg::CMD_CLEAR, 8'h00, 1'b0, 8'h00);
    drain_requests();
    write_register(lcdns_pkg::CFG_SHORT_HOLD, 16'h00A5);
    write_register(lcdns_pkg::CFG_LONG_HOLD, 16'h5A00);
    write_register(lcdns_pkg::CFG_IDX_W'(2), 16'h1234);
    write_register(lcdns_pkg::CFG_IDX_W'(3), 16'hFFFF);
    send_request(lcdns_pkg::CMD_CURSOR, 8'h00, 1'b1, 8'h03);
    send_request(lcdns_pkg::CMD_DATA, 8'h3C, 1'b1, 8'h00);
    drain_requests();
  endtask

  // Random requests under two random hold settings at the given sender
  // idle rate. Mostly valid codes with random fields; a few unknown codes
  // and a modest share of init, which is the longest program.
  task automatic test_random_traffic(int idle_rate, int count);
    int                          pick;
    logic [lcdns_pkg::CMD_W-1:0] cmd;
    idle_percent = idle_rate;
    for (int setting = 0; setting < 2; setting++) begin
      drain_requests();
      write_register(lcdns_pkg::CFG_SHORT_HOLD, pick_hold());
      write_register(lcdns_pkg::CFG_LONG_HOLD, pick_hold());
      for (int n = 0; n < count / 2; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6)
          cmd = lcdns_pkg::CMD_W'($urandom_range(5, 7));
        else if (pick < 16)
          cmd = lcdns_pkg::CMD_INIT;
        else
          cmd = lcdns_pkg::CMD_W'($urandom_range(lcdns_pkg::CMD_BYTE, lcdns_pkg::CMD_CLEAR));
        send_request(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
      end
    end
    drain_requests();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_cmd           = lcdns_pkg::CMD_INIT;
    in_byte_value    = '0;
    in_row           = 1'b0;
    in_column        = '0;
    cfg_we           = 1'b0;
    cfg_index        = lcdns_pkg::CFG_SHORT_HOLD;
    cfg_data         = '0;
    model_short_hold = lcdns_pkg::SHORT_HOLD_RESET;
    model_long_hold  = lcdns_pkg::LONG_HOLD_RESET;
    idle_percent     = 0;
    mismatch_count   = 0;
    segments_compared = 0;
    foreach (requests_by_code[i]) requests_by_code[i] = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_holds();
    test_directed_requests();
    test_hold_extremes();
    test_random_traffic(22, 60);
    test_random_traffic(72, 60);
    test_random_traffic(0, 60);

    $display("Run covered %0d init, %0d command, %0d data, %0d cursor, %0d clear requests",
             requests_by_code[lcdns_pkg::CMD_INIT], requests_by_code[lcdns_pkg::CMD_BYTE],
             requests_by_code[lcdns_pkg::CMD_DATA], requests_by_code[lcdns_pkg::CMD_CURSOR],
             requests_by_code[lcdns_pkg::CMD_CLEAR]);
    $display("plus %0d unknown codes; %0d segments compared, %0d mismatches",
             requests_by_code[5] + requests_by_code[6] + requests_by_code[7],
             segments_compared, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400us;
    $display("Timeout: simulation did not finish");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/lcdns_pkg.sv
design/lcdns_sequencer.sv
design/lcdns_datapath.sv
design/char_lcd_nibble_sequencer.sv
verif/char_lcd_nibble_sequencer_tb.sv
